[hw/rtl/pac_pkg.sv]
// pac_pkg: widths, saturation limits and the controller/datapath interface structs
// for the polygon area and centroid block
// no dependencies
package pac_pkg;

   localparam int COORD_BITS   = 16;                 // signed q8.8 coordinate
   localparam int PROD_BITS    = 2 * COORD_BITS;     // one coordinate product
   localparam int CROSS_BITS   = PROD_BITS + 1;      // px*qy - qx*py
   localparam int PAIR_BITS    = COORD_BITS + 1;     // px + qx
   localparam int WPROD_BITS   = PAIR_BITS + CROSS_BITS;
   localparam int AREA_BITS    = 48;                 // doubled area, wraps
   localparam int WSUM_BITS    = 64;                 // weighted sums, wrap
   localparam int DEN_BITS     = AREA_BITS + 2;      // three times the doubled area
   localparam int QIDX_BITS    = $clog2(COORD_BITS);
   localparam int STEP_BITS    = $clog2(COORD_BITS + 1);
   localparam int DIV_BITS     = WSUM_BITS + 2;      // shifted divisor

   localparam logic [COORD_BITS-1:0] SAT_POS = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic [COORD_BITS-1:0] SAT_NEG = {1'b1, {(COORD_BITS-1){1'b0}}};

   localparam int MAX_VERTICES_DEF = 65536;

   // controller to datapath
   typedef struct packed {
      logic load_in;     // capture the accepted word
      logic first_cap;   // first vertex of a polygon
      logic mul;         // edge products and pair sums
      logic close;       // closing edge: current to first vertex
      logic xprod;       // cross product
      logic acc;         // area sum and weighted products
      logic sum;         // weighted sums
      logic prep;        // denominator and degenerate flag
      logic div_start;
      logic div_sel_y;   // divide the y sum
      logic store_x;
      logic store_y;
      logic load_out;    // fill the result register
      logic ovf;         // overflow flag for the result
      logic clear;       // start a new polygon
   } pac_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;
      logic degen;
      logic div_done;
   } pac_stat_type;

endpackage

[hw/rtl/polygon_area_centroid.sv]
// polygon_area_centroid: top level of the streaming shoelace area and centroid block
// instantiates pac_ctrl and pac_dp; uses pac_pkg
//
//  channel | direction | word
//  req_*   | in        | tdata {vertex_y, vertex_x}, tlast last_vertex
//  rsp_*   | out       | tdata {centroid_y, centroid_x, double_area}, tuser {overflow, degenerate}
//
//  a vertex passes through an update step and a 4-step edge pipeline (products,
//  cross, area and weighted products, weighted sums) before the next word is taken
//  the last vertex adds the closing edge, a prep step and two 17-step divisions in
//  the shared divider; a degenerate polygon skips the divisions
//  the result sits in an output register; a stalled rsp side holds the next polygon's
//  result and blocks further vertices. synchronous reset clears the count, sums and handshakes
module polygon_area_centroid #(
   parameter int MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // vertex_x [15:0], vertex_y [31:16]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // double_area [47:0], centroid_x [63:48], centroid_y [79:64]
   output logic [1:0]  rsp_tuser    // degenerate [0], overflow [1]
);

   pac_pkg::pac_cmd_type  cmd;
   pac_pkg::pac_stat_type stat;

   logic [pac_pkg::AREA_BITS-1:0]  out_area;
   logic [pac_pkg::COORD_BITS-1:0] out_cx, out_cy;
   logic                           out_degen, out_ovf;

   pac_ctrl #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pac_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .in_x      ($signed(req_tdata[15:0])),
      .in_y      ($signed(req_tdata[31:16])),
      .in_last   (req_tlast),
      .out_area  (out_area),
      .out_cx    (out_cx),
      .out_cy    (out_cy),
      .out_degen (out_degen),
      .out_ovf   (out_ovf)
   );

   assign rsp_tdata = {out_cy, out_cx, out_area};
   assign rsp_tuser = {out_ovf, out_degen};

endmodule

[hw/rtl/pac_div.sv]
// pac_div: sequential restoring divider for one centroid coordinate
// signed 64-bit sum over signed denominator, truncated and saturated; uses pac_pkg
module pac_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [pac_pkg::WSUM_BITS-1:0]  num,
   input  logic signed [pac_pkg::DEN_BITS-1:0]   den,
   output logic                                  done,
   output logic        [pac_pkg::COORD_BITS-1:0] quot
);

   logic [pac_pkg::WSUM_BITS-1:0]  rem_ff, rem_in;
   logic [pac_pkg::DIV_BITS-1:0]   div_ff, div_in;
   logic [pac_pkg::COORD_BITS-1:0] q_ff, q_in;
   logic [pac_pkg::STEP_BITS-1:0]  step_ff, step_in;
   logic                           big_ff, big_in;
   logic                           neg_ff, neg_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [pac_pkg::DEN_BITS-1:0]   den_mag;
   logic                           ge;

   assign den_mag = den[pac_pkg::DEN_BITS-1] ? pac_pkg::DEN_BITS'(-den)
                                              : pac_pkg::DEN_BITS'(den);
   assign ge = {2'b00, rem_ff} >= div_ff;

   always_comb begin
      rem_in  = rem_ff;
      div_in  = div_ff;
      q_in    = q_ff;
      step_in = step_ff;
      big_in  = big_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num[pac_pkg::WSUM_BITS-1] ? pac_pkg::WSUM_BITS'(-num)
                                               : pac_pkg::WSUM_BITS'(num);
         div_in  = pac_pkg::DIV_BITS'(den_mag) << pac_pkg::COORD_BITS;
         q_in    = '0;
         step_in = pac_pkg::STEP_BITS'(pac_pkg::COORD_BITS);
         big_in  = 1'b0;
         neg_in  = num[pac_pkg::WSUM_BITS-1] ^ den[pac_pkg::DEN_BITS-1];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // top step only checks whether the quotient leaves the coordinate range
         if (step_ff == pac_pkg::STEP_BITS'(pac_pkg::COORD_BITS)) begin
            big_in = ge;
         end else if (ge) begin
            rem_in = rem_ff - div_ff[pac_pkg::WSUM_BITS-1:0];
            q_in[step_ff[pac_pkg::QIDX_BITS-1:0]] = 1'b1;
         end
         div_in = div_ff >> 1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      q_ff    <= q_in;
      step_ff <= step_in;
      big_ff  <= big_in;
      neg_ff  <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;

   always_comb begin
      if (neg_ff) begin
         if (big_ff || q_ff > pac_pkg::SAT_NEG) begin
            quot = pac_pkg::SAT_NEG;
         end else begin
            quot = pac_pkg::COORD_BITS'(-q_ff);
         end
      end else begin
         if (big_ff || q_ff > pac_pkg::SAT_POS) begin
            quot = pac_pkg::SAT_POS;
         end else begin
            quot = q_ff;
         end
      end
   end

endmodule

[hw/rtl/pac_dp.sv]
// pac_dp: vertex registers, shoelace edge pipeline, sums and result register
// driven by pac_ctrl commands; uses pac_pkg and pac_div
module pac_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pac_pkg::pac_cmd_type                  cmd,
   output pac_pkg::pac_stat_type                 stat,
   input  logic signed [pac_pkg::COORD_BITS-1:0] in_x,
   input  logic signed [pac_pkg::COORD_BITS-1:0] in_y,
   input  logic                                  in_last,
   output logic        [pac_pkg::AREA_BITS-1:0]  out_area,
   output logic        [pac_pkg::COORD_BITS-1:0] out_cx,
   output logic        [pac_pkg::COORD_BITS-1:0] out_cy,
   output logic                                  out_degen,
   output logic                                  out_ovf
);

   logic signed [pac_pkg::COORD_BITS-1:0] cur_x_ff, cur_y_ff, first_x_ff, first_y_ff;
   logic signed [pac_pkg::COORD_BITS-1:0] prev_x_ff, prev_y_ff;
   logic                                  last_ff;
   logic signed [pac_pkg::COORD_BITS-1:0] px, py, qx, qy;
   logic signed [pac_pkg::PROD_BITS-1:0]  m1_ff, m1_in, m2_ff, m2_in;
   logic signed [pac_pkg::PAIR_BITS-1:0]  sx_ff, sx_in, sy_ff, sy_in;
   logic signed [pac_pkg::CROSS_BITS-1:0] c_ff, c_in;
   logic signed [pac_pkg::WPROD_BITS-1:0] wpx_ff, wpx_in, wpy_ff, wpy_in;
   logic        [pac_pkg::AREA_BITS-1:0]  area_ff, area_in;
   logic        [pac_pkg::WSUM_BITS-1:0]  wx_ff, wx_in, wy_ff, wy_in;
   logic signed [pac_pkg::DEN_BITS-1:0]   den_ff, den_in;
   logic                                  degen_ff;
   logic        [pac_pkg::COORD_BITS-1:0] cx_ff, cy_ff;
   logic        [pac_pkg::AREA_BITS-1:0]  rsp_area_ff;
   logic        [pac_pkg::COORD_BITS-1:0] rsp_cx_ff, rsp_cy_ff;
   logic                                  rsp_degen_ff, rsp_ovf_ff;
   logic signed [pac_pkg::WSUM_BITS-1:0]  div_num;
   logic                                  div_done;
   logic        [pac_pkg::COORD_BITS-1:0] div_quot;

   // open edge runs prev -> cur, the closing edge cur -> first
   assign px = cmd.close ? cur_x_ff   : prev_x_ff;
   assign py = cmd.close ? cur_y_ff   : prev_y_ff;
   assign qx = cmd.close ? first_x_ff : cur_x_ff;
   assign qy = cmd.close ? first_y_ff : cur_y_ff;

   assign m1_in  = px * qy;
   assign m2_in  = qx * py;
   assign sx_in  = $signed({px[pac_pkg::COORD_BITS-1], px}) +
                   $signed({qx[pac_pkg::COORD_BITS-1], qx});
   assign sy_in  = $signed({py[pac_pkg::COORD_BITS-1], py}) +
                   $signed({qy[pac_pkg::COORD_BITS-1], qy});
   assign c_in   = $signed({m1_ff[pac_pkg::PROD_BITS-1], m1_ff}) -
                   $signed({m2_ff[pac_pkg::PROD_BITS-1], m2_ff});
   assign wpx_in = sx_ff * c_ff;
   assign wpy_in = sy_ff * c_ff;
   assign area_in = area_ff + {{(pac_pkg::AREA_BITS-pac_pkg::CROSS_BITS)
                               {c_ff[pac_pkg::CROSS_BITS-1]}}, c_ff};
   assign wx_in  = wx_ff + {{(pac_pkg::WSUM_BITS-pac_pkg::WPROD_BITS)
                             {wpx_ff[pac_pkg::WPROD_BITS-1]}}, wpx_ff};
   assign wy_in  = wy_ff + {{(pac_pkg::WSUM_BITS-pac_pkg::WPROD_BITS)
                             {wpy_ff[pac_pkg::WPROD_BITS-1]}}, wpy_ff};
   // 3a = a + 2a
   assign den_in = $signed({{2{area_ff[pac_pkg::AREA_BITS-1]}}, area_ff}) +
                   $signed({area_ff[pac_pkg::AREA_BITS-1], area_ff, 1'b0});

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         cur_x_ff <= in_x;
         cur_y_ff <= in_y;
         last_ff  <= in_last;
      end
      if (cmd.first_cap) begin
         first_x_ff <= cur_x_ff;
         first_y_ff <= cur_y_ff;
         prev_x_ff  <= cur_x_ff;
         prev_y_ff  <= cur_y_ff;
      end else if (cmd.mul && !cmd.close) begin
         prev_x_ff <= cur_x_ff;
         prev_y_ff <= cur_y_ff;
      end
      if (cmd.mul) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
         sx_ff <= sx_in;
         sy_ff <= sy_in;
      end
      if (cmd.xprod) begin
         c_ff <= c_in;
      end
      if (cmd.acc) begin
         wpx_ff <= wpx_in;
         wpy_ff <= wpy_in;
      end
      if (cmd.prep) begin
         den_ff   <= den_in;
         degen_ff <= (area_ff == '0);
      end
      if (cmd.store_x) begin
         cx_ff <= div_quot;
      end
      if (cmd.store_y) begin
         cy_ff <= div_quot;
      end
      if (cmd.load_out) begin
         rsp_area_ff  <= area_ff;
         rsp_cx_ff    <= degen_ff ? '0 : cx_ff;
         rsp_cy_ff    <= degen_ff ? '0 : cy_ff;
         rsp_degen_ff <= degen_ff;
         rsp_ovf_ff   <= cmd.ovf;
      end
      if (reset || cmd.clear) begin
         area_ff <= '0;
         wx_ff   <= '0;
         wy_ff   <= '0;
      end else begin
         if (cmd.acc) begin
            area_ff <= area_in;
         end
         if (cmd.sum) begin
            wx_ff <= wx_in;
            wy_ff <= wy_in;
         end
      end
   end

   assign div_num = cmd.div_sel_y ? $signed(wy_ff) : $signed(wx_ff);

   pac_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign stat.last     = last_ff;
   assign stat.degen    = degen_ff;
   assign stat.div_done = div_done;

   assign out_area  = rsp_area_ff;
   assign out_cx    = rsp_cx_ff;
   assign out_cy    = rsp_cy_ff;
   assign out_degen = rsp_degen_ff;
   assign out_ovf   = rsp_ovf_ff;

endmodule

[hw/rtl/pac_ctrl.sv]
// pac_ctrl: sequencer for vertex intake, edge steps, the two divisions and the
// result handshake; owns the vertex count; uses pac_pkg
module pac_ctrl #(
   parameter int MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   input  pac_pkg::pac_stat_type stat,
   output pac_pkg::pac_cmd_type  cmd
);

   localparam int CNT_BITS = $clog2(MAX_VERTICES + 2);
   localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_VERTICES);

   typedef enum logic [3:0] {
      S_IDLE,
      S_UPDATE,
      S_MUL,
      S_CROSS,
      S_ACC,
      S_SUM,
      S_PREP,
      S_DIVX,
      S_WAITX,
      S_DIVY,
      S_WAITY,
      S_OUT
   } state_type;

   state_type           state_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                close_ff;
   logic                valid_ff;
   logic                out_free;

   assign out_free = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         close_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (out_ready) begin
            valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (in_valid) begin
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               if (count_ff <= CNT_MAX) begin
                  count_ff <= count_ff + 1'b1;
               end
               state_ff <= S_MUL;
            end
            S_MUL:   state_ff <= S_CROSS;
            S_CROSS: state_ff <= S_ACC;
            S_ACC:   state_ff <= S_SUM;
            S_SUM: begin
               if (close_ff) begin
                  state_ff <= S_PREP;
               end else if (stat.last) begin
                  close_ff <= 1'b1;
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_PREP: begin
               // area taken from the sums before the flag settles, so decide in S_DIVX
               state_ff <= S_DIVX;
            end
            S_DIVX: begin
               state_ff <= stat.degen ? S_OUT : S_WAITX;
            end
            S_WAITX: begin
               if (stat.div_done) begin
                  state_ff <= S_DIVY;
               end
            end
            S_DIVY:  state_ff <= S_WAITY;
            S_WAITY: begin
               if (stat.div_done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  valid_ff <= 1'b1;
                  count_ff <= '0;
                  close_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.close     = close_ff;
      cmd.ovf       = count_ff > CNT_MAX;
      cmd.load_in   = (state_ff == S_IDLE) && in_valid;
      cmd.first_cap = (state_ff == S_UPDATE) && (count_ff == '0);
      cmd.mul       = (state_ff == S_MUL);
      cmd.xprod     = (state_ff == S_CROSS);
      cmd.acc       = (state_ff == S_ACC);
      cmd.sum       = (state_ff == S_SUM);
      cmd.prep      = (state_ff == S_PREP);
      cmd.div_start = ((state_ff == S_DIVX) && !stat.degen) || (state_ff == S_DIVY);
      cmd.div_sel_y = (state_ff == S_DIVY);
      cmd.store_x   = (state_ff == S_WAITX) && stat.div_done;
      cmd.store_y   = (state_ff == S_WAITY) && stat.div_done;
      cmd.load_out  = (state_ff == S_OUT) && out_free;
      cmd.clear     = cmd.load_out;
   end

   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = valid_ff;

endmodule

[dv/testbench.sv]
// testbench for polygon_area_centroid: streams polygons through the req channel and checks
// each rsp word against a shoelace area and centroid predictor kept in the bench
// depends on pac_pkg and the polygon_area_centroid rtl
`timescale 1ns / 100ps

module testbench;

   localparam int MAX_VERTS  = pac_pkg::MAX_VERTICES_DEF;
   localparam int STALL_LIMIT = 4000;   // longest rsp hold-off plus one polygon, several times
   localparam int LONG_HOLD   = 600;
   localparam int HOLD_AT     = 30;     // result index where the long rsp hold-off starts

   typedef struct {
      logic signed [pac_pkg::COORD_BITS-1:0] x;
      logic signed [pac_pkg::COORD_BITS-1:0] y;
      logic                                  last;
      int                                    gap;     // idle cycles after this word
      bit                                    drain;   // hold until every result is back
   } vertex_word_type;

   typedef struct packed {
      logic [pac_pkg::AREA_BITS-1:0]         double_area;
      logic signed [pac_pkg::COORD_BITS-1:0] centroid_x;
      logic signed [pac_pkg::COORD_BITS-1:0] centroid_y;
      logic                                  degenerate;
      logic                                  overflow;
   } polygon_result_type;

   typedef enum {SHAPE_WIDE, SHAPE_LOCAL, SHAPE_LINE, SHAPE_POINT, SHAPE_BOWTIE} poly_shape_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // vertex_x [15:0], vertex_y [31:16]
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // double_area [47:0], centroid_x [63:48], centroid_y [79:64]
   logic [1:0]  rsp_tuser;        // degenerate [0], overflow [1]

   vertex_word_type    vertex_q[$];
   polygon_result_type centroid_expect_q[$];
   vertex_word_type    drive_word;
   polygon_result_type want_res, next_res;

   // predictor state
   logic signed [pac_pkg::COORD_BITS-1:0] poly_first_x, poly_first_y, poly_prev_x, poly_prev_y;
   logic [pac_pkg::AREA_BITS-1:0]         area_acc;
   logic [pac_pkg::WSUM_BITS-1:0]         wx_acc, wy_acc;
   int                                    poly_count;

   int send_wait, recv_wait, rsp_taken, stall_cycles;
   int mismatches, vertices_in, results_checked, degen_seen, sat_seen, ovf_seen;
   int random_vertices;

   polygon_area_centroid dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string field, input longint got, input longint want);
      mismatches++;
      $display("mismatch in %s at result %0d: got %0d, want %0d",
               field, results_checked, got, want);
   endtask

   function automatic void clear_polygon();
      poly_first_x = '0;
      poly_first_y = '0;
      poly_prev_x  = '0;
      poly_prev_y  = '0;
      area_acc     = '0;
      wx_acc       = '0;
      wy_acc       = '0;
      poly_count   = 0;
   endfunction

   function automatic void shoelace_edge(input longint px, input longint py,
                                         input longint qx, input longint qy);
      longint cprod;
      cprod    = px * qy - qx * py;
      area_acc = area_acc + cprod[pac_pkg::AREA_BITS-1:0];
      wx_acc   = wx_acc + (px + qx) * cprod;
      wy_acc   = wy_acc + (py + qy) * cprod;
   endfunction

   // quotient truncates toward zero, then clamps to the q8.8 range
   function automatic logic signed [pac_pkg::COORD_BITS-1:0] centroid_coord(input longint num,
                                                                            input longint den);
      longint q;
      q = num / den;
      if (q > longint'($signed(pac_pkg::SAT_POS)))
         q = $signed(pac_pkg::SAT_POS);
      else if (q < longint'($signed(pac_pkg::SAT_NEG)))
         q = $signed(pac_pkg::SAT_NEG);
      return q[pac_pkg::COORD_BITS-1:0];
   endfunction

   function automatic bit polygon_step(input logic signed [pac_pkg::COORD_BITS-1:0] vx,
                                       input logic signed [pac_pkg::COORD_BITS-1:0] vy,
                                       input logic last, output polygon_result_type res);
      longint a2;
      res = '0;
      if (poly_count == 0) begin
         poly_first_x = vx;
         poly_first_y = vy;
      end else begin
         shoelace_edge(poly_prev_x, poly_prev_y, vx, vy);
      end
      poly_prev_x = vx;
      poly_prev_y = vy;
      if (poly_count <= MAX_VERTS)
         poly_count++;
      if (!last)
         return 1'b0;
      // closing edge back to the first vertex
      shoelace_edge(vx, vy, poly_first_x, poly_first_y);
      a2              = $signed(area_acc);
      res.double_area = area_acc;
      res.degenerate  = (area_acc == '0);
      res.overflow    = (poly_count > MAX_VERTS);
      if (!res.degenerate) begin
         res.centroid_x = centroid_coord($signed(wx_acc), 3 * a2);
         res.centroid_y = centroid_coord($signed(wy_acc), 3 * a2);
      end
      clear_polygon();
      return 1'b1;
   endfunction

   task automatic add_vertex(input int px, input int py, input bit last, input int gap,
                             input bit drain);
      vertex_word_type w;
      w.x     = px[pac_pkg::COORD_BITS-1:0];
      w.y     = py[pac_pkg::COORD_BITS-1:0];
      w.last  = last;
      w.gap   = gap;
      w.drain = drain;
      vertex_q.push_back(w);
   endtask

   function automatic int any_coord();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   task automatic add_random_polygon(input bit drain);
      int             n, k, cx0, cy0, a, d, px, py, sel;
      bit             burst, flip;
      poly_shape_type shape;
      sel = $urandom_range(0, 9);
      if (sel < 4)
         shape = SHAPE_WIDE;
      else if (sel < 7)
         shape = SHAPE_LOCAL;
      else if (sel == 7)
         shape = SHAPE_LINE;
      else if (sel == 8)
         shape = ($urandom_range(0, 1) == 0) ? SHAPE_POINT : SHAPE_LINE;
      else
         shape = SHAPE_BOWTIE;
      burst = ($urandom_range(0, 3) == 0);
      n     = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      cx0   = any_coord();
      cy0   = any_coord();
      a     = $urandom_range(2, 32767);
      d     = $urandom_range(1, 3);
      flip  = $urandom_range(0, 1);
      if (shape == SHAPE_BOWTIE)
         n = 4;
      if (shape == SHAPE_LOCAL) begin
         cx0 = cx0 / 2;
         cy0 = cy0 / 2;
      end
      for (k = 0; k < n; k++) begin
         case (shape)
            SHAPE_WIDE: begin
               px = any_coord();
               py = any_coord();
            end
            SHAPE_LOCAL: begin
               px = cx0 + int'($urandom_range(0, 4095)) - 2048;
               py = cy0 + int'($urandom_range(0, 4095)) - 2048;
            end
            SHAPE_LINE: begin
               px = flip ? cx0 : any_coord();
               py = flip ? any_coord() : cy0;
            end
            SHAPE_POINT: begin
               px = cx0;
               py = cy0;
            end
            default: begin
               // crossed quad whose lobes nearly cancel: tiny area, large weighted sums
               px = (k == 0 || k == 2) ? -a : ((k == 3) ? a - d : a);
               py = (k < 2) ? -a : a;
               if (flip)
                  py = -py;
            end
         endcase
         add_vertex(px, py, k == n - 1, burst ? 0 : $urandom_range(0, 17), drain && k == 0);
         random_vertices++;
      end
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait  <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_wait != 0) begin
            req_tvalid <= 1'b0;
            send_wait  <= send_wait - 1;
         end else if (vertex_q.size() != 0 &&
                      !(vertex_q[0].drain && (req_tvalid || centroid_expect_q.size() != 0))) begin
            drive_word = vertex_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {drive_word.y, drive_word.x};
            req_tlast  <= drive_word.last;
            send_wait  <= drive_word.gap;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait  <= $urandom_range(0, 17);
         rsp_taken  <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_taken <= rsp_taken + 1;
         if (rsp_taken == HOLD_AT) begin
            rsp_tready <= 1'b0;
            recv_wait  <= LONG_HOLD;
         end else if ((rsp_taken / 25) % 4 == 3) begin
            rsp_tready <= 1'b1;
            recv_wait  <= 0;
         end else begin
            recv_wait  <= $urandom_range(0, 17);
            rsp_tready <= 1'b0;
         end
      end else if (recv_wait != 0) begin
         recv_wait  <= recv_wait - 1;
         rsp_tready <= (recv_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: predict on accepted vertices, check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            vertices_in++;
            if (polygon_step(req_tdata[15:0], req_tdata[31:16], req_tlast, next_res))
               centroid_expect_q.push_back(next_res);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (centroid_expect_q.size() == 0) begin
               report_mismatch("unexpected result word", $signed(rsp_tdata[47:0]), 0);
            end else begin
               want_res = centroid_expect_q.pop_front();
               if (rsp_tdata[47:0] !== want_res.double_area)
                  report_mismatch("double_area", $signed(rsp_tdata[47:0]),
                                  $signed(want_res.double_area));
               if (rsp_tdata[63:48] !== want_res.centroid_x)
                  report_mismatch("centroid_x", $signed(rsp_tdata[63:48]), want_res.centroid_x);
               if (rsp_tdata[79:64] !== want_res.centroid_y)
                  report_mismatch("centroid_y", $signed(rsp_tdata[79:64]), want_res.centroid_y);
               if (rsp_tuser[0] !== want_res.degenerate)
                  report_mismatch("degenerate", rsp_tuser[0], want_res.degenerate);
               if (rsp_tuser[1] !== want_res.overflow)
                  report_mismatch("overflow", rsp_tuser[1], want_res.overflow);
               if (want_res.degenerate)
                  degen_seen++;
               else if (want_res.centroid_x == pac_pkg::SAT_POS ||
                        want_res.centroid_x == pac_pkg::SAT_NEG ||
                        want_res.centroid_y == pac_pkg::SAT_POS ||
                        want_res.centroid_y == pac_pkg::SAT_NEG)
                  sat_seen++;
               if (want_res.overflow)
                  ovf_seen++;
            end
            results_checked++;
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d idle cycles", stall_cycles);
         $display("[polygon_area_centroid] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      clear_polygon();
      // directed: single vertices at the corners of the range
      add_vertex(-32768, 32767, 1, 0, 0);
      add_vertex(32767, -32768, 1, 3, 0);
      // counterclockwise and clockwise triangle
      add_vertex(0, 0, 0, 0, 0);
      add_vertex(1024, 0, 0, 0, 0);
      add_vertex(0, 1024, 1, 5, 0);
      add_vertex(0, 0, 0, 0, 0);
      add_vertex(0, 1024, 0, 2, 0);
      add_vertex(1024, 0, 1, 0, 0);
      // full-range triangle
      add_vertex(-32768, -32768, 0, 0, 0);
      add_vertex(32767, -32768, 0, 0, 0);
      add_vertex(32767, 32767, 1, 0, 0);
      // collinear points: zero area
      add_vertex(-32768, 0, 0, 1, 0);
      add_vertex(0, 0, 0, 0, 0);
      add_vertex(32767, 0, 1, 0, 0);
      // crossed quad with exactly cancelling lobes, then nearly cancelling
      add_vertex(-32767, -32767, 0, 0, 0);
      add_vertex(32767, -32767, 0, 0, 0);
      add_vertex(-32767, 32767, 0, 0, 0);
      add_vertex(32767, 32767, 1, 0, 0);
      add_vertex(-32767, -32767, 0, 0, 0);
      add_vertex(32767, -32767, 0, 0, 0);
      add_vertex(-32767, 32767, 0, 0, 0);
      add_vertex(32766, 32767, 1, 0, 0);

      random_vertices = 0;
      add_random_polygon(1'b1);
      while (random_vertices < 700)
         add_random_polygon($urandom_range(0, 49) == 0);
      add_random_polygon(1'b1);
      while (random_vertices < 1430)
         add_random_polygon($urandom_range(0, 49) == 0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (vertex_q.size() != 0 || req_tvalid || centroid_expect_q.size() != 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
      if (centroid_expect_q.size() != 0)
         report_mismatch("results never returned", centroid_expect_q.size(), 0);

      $display("sent %0d vertices, checked %0d polygon results", vertices_in, results_checked);
      $display("degenerate %0d, saturated centroid %0d, vertex overflow %0d",
               degen_seen, sat_seen, ovf_seen);
      if (mismatches == 0)
         $display("[polygon_area_centroid] OK");
      else
         $display("[polygon_area_centroid] ERROR");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/pac_pkg.sv
hw/rtl/pac_div.sv
hw/rtl/pac_dp.sv
hw/rtl/pac_ctrl.sv
hw/rtl/polygon_area_centroid.sv
dv/testbench.sv
